FILE: sv/hpf_pkg.sv
// Shared types, codes and constant tables for the harmonic pitch frequency block.
// Used by every module of the block; depends on nothing else.
package hpf_pkg;

    // Divider widths: signed dividend and unsigned divisor.
    localparam int DIV_DW = 24;
    localparam int DIV_VW = 11;
    // Widest table index the default ratio lookup supports.
    localparam int TIDX_W = 6;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // Which quotient the shared divider is producing.
    localparam logic [1:0] DIV_OCT = 2'd0;
    localparam logic [1:0] DIV_TQ  = 2'd1;

    // Configuration register indexes.
    localparam logic [2:0] REG_FUND  = 3'd0;
    localparam logic [2:0] REG_LEN   = 3'd1;
    localparam logic [2:0] REG_RANGE = 3'd2;
    localparam logic [2:0] REG_LOW   = 3'd3;
    localparam logic [2:0] REG_HIGH  = 3'd4;

    // Configuration reset values.
    localparam logic [23:0] FUND_RST  = 24'd450560;
    localparam logic [4:0]  LEN_RST   = 5'd12;
    localparam logic [5:0]  RANGE_RST = 6'd12;
    localparam logic [7:0]  LOW_RST   = 8'hD0;
    localparam logic [7:0]  HIGH_RST  = 8'd96;

    localparam logic [23:0] ONE_Q22      = 24'd4194304;
    localparam logic [63:0] ONE_Q30      = 64'd1073741824;
    localparam logic [63:0] LN2_Q30      = 64'd744261118;
    localparam int          SERIES_TERMS = 24;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load;
        logic       num;
        logic       mval;
        logic       div_start;
        logic [1:0] div_op;
        logic       rd;
        logic       ma;
        logic       mh;
        logic       ml;
        logic       sc;
        logic       out_load;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_write;
        logic is_reject;
        logic div_done;
        logic out_free;
    } stat_t;

    // Reset contents of the tuning table: just intonation, then unity.
    function automatic logic [23:0] just_ratio(input logic [TIDX_W-1:0] i);
        logic [23:0] r;
        case (i)
            6'd0:    r = 24'd4194304;
            6'd1:    r = 24'd4473924;
            6'd2:    r = 24'd4718592;
            6'd3:    r = 24'd5033165;
            6'd4:    r = 24'd5242880;
            6'd5:    r = 24'd5592405;
            6'd6:    r = 24'd5898240;
            6'd7:    r = 24'd6291456;
            6'd8:    r = 24'd6710886;
            6'd9:    r = 24'd6990507;
            6'd10:   r = 24'd7549747;
            6'd11:   r = 24'd7864320;
            default: r = ONE_Q22;
        endcase
        return r;
    endfunction

    // Truncating exponential series in Q2.30, evaluated at elaboration only.
    function automatic logic [31:0] exp_series(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = ((term * x) >> 30) / 64'(n);
            sum  = sum + term;
        end
        return sum[31:0];
    endfunction

endpackage

FILE: sv/hpf_div.sv
// Shared restoring divider with floor semantics for a signed dividend.
// Depends on hpf_pkg for its widths.
module hpf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [hpf_pkg::DIV_DW-1:0] dividend,
    input  logic [hpf_pkg::DIV_VW-1:0]    divisor,
    output logic signed [hpf_pkg::DIV_DW-1:0] quotient,
    output logic [hpf_pkg::DIV_VW-1:0]    remainder,
    output logic                          done
);
    import hpf_pkg::*;

    localparam int CW = $clog2(DIV_DW + 1);

    logic              busy_reg, fix_reg, done_reg, neg_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DIV_DW-1:0] quo_reg;
    logic [DIV_VW-1:0] rem_reg, d_reg;
    logic signed [DIV_DW-1:0] q_out_reg;
    logic [DIV_VW-1:0] r_out_reg;

    logic [DIV_VW:0]   rem_sh;
    logic              ge;
    logic [DIV_VW-1:0] rem_next;
    logic [DIV_DW-1:0] mag;

    // One quotient bit per cycle.
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[DIV_DW-1]};
        ge       = rem_sh >= {1'b0, d_reg};
        rem_next = ge ? DIV_VW'(rem_sh - {1'b0, d_reg}) : DIV_VW'(rem_sh);
        mag      = dividend[DIV_DW-1] ? DIV_DW'(-dividend) : DIV_DW'(dividend);
    end

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fix_reg;
            fix_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_DW - 1)) begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end
        end
    end

    // Shift registers and the final sign correction.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= mag;
            rem_reg <= '0;
            d_reg   <= divisor;
            neg_reg <= dividend[DIV_DW-1];
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_DW-2:0], ge};
            rem_reg <= rem_next;
        end
        if (fix_reg) begin
            if (neg_reg && rem_reg != '0) begin
                q_out_reg <= $signed(~quo_reg);
                r_out_reg <= d_reg - rem_reg;
            end else if (neg_reg) begin
                q_out_reg <= $signed(DIV_DW'(0) - quo_reg);
                r_out_reg <= rem_reg;
            end else begin
                q_out_reg <= $signed(quo_reg);
                r_out_reg <= rem_reg;
            end
        end
    end

    assign quotient  = q_out_reg;
    assign remainder = r_out_reg;
    assign done      = done_reg;

endmodule

FILE: sv/hpf_datapath.sv
// Datapath: tuning table, exponent table, multipliers, divider and result registers.
// Depends on hpf_pkg and hpf_div.
module hpf_datapath #(
    parameter int TABLE_DEPTH     = 16,
    parameter int EXP_TABLE_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  hpf_pkg::cmd_t      cmd,
    output hpf_pkg::stat_t     stat,
    input  logic               s_func,
    input  logic [3:0]         s_entry_index,
    input  logic [23:0]        s_ratio_value,
    input  logic signed [7:0]  s_harm_number,
    input  logic signed [7:0]  s_harm_offset,
    input  logic signed [15:0] s_shift_amount,
    input  logic signed [15:0] s_shift_five,
    input  logic [23:0]        cfg_fund,
    input  logic [4:0]         cfg_len,
    input  logic [5:0]         cfg_range,
    input  logic signed [7:0]  cfg_low,
    input  logic signed [7:0]  cfg_high,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_frequency,
    output logic [1:0]         m_status
);
    import hpf_pkg::*;

    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KW = $clog2(EXP_TABLE_DEPTH);

    // Exponent table: 2^(k/depth) in Q2.30.
    logic [31:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
        localparam logic [63:0] XK = 64'(g) * LN2_Q30 / EXP_TABLE_DEPTH;
        assign exp_rom[g] = exp_series(XK);
    end

    // Tuning table with per-entry written flags.
    logic [23:0]            tbl_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] tbl_vld_reg;

    logic signed [8:0]        t_reg;
    logic signed [15:0]       sh_reg, sh5_reg;
    logic signed [25:0]       num_reg;
    logic signed [DIV_DW-1:0] mv_reg, oct_reg;
    logic signed [DIV_DW:0]   p_reg;
    logic [TW-1:0]            idx_reg;
    logic [KW-1:0]            k_reg;
    logic [1:0]               op_reg;
    logic [23:0]              rd_mem_reg, rd_def_reg;
    logic                     rd_vld_reg;
    logic [31:0]              e_reg;
    logic [47:0]              a_reg;
    logic [55:0]              ph_reg;
    logic [79:0]              prod_reg;
    logic [31:0]              res_freq_reg, last_freq_reg, m_freq_reg;
    logic [1:0]               res_status_reg, m_status_reg;
    logic                     m_valid_reg;

    logic                     reject, wr_ok;
    logic [DIV_VW-1:0]        len_c;
    logic [DIV_VW+2:0]        len5;
    logic signed [31:0]       mul_a, mul_b;
    logic signed [39:0]       n_val;
    logic signed [DIV_DW-1:0] div_a, div_q;
    logic [DIV_VW-1:0]        div_d, div_r;
    logic                     div_done;
    logic signed [26:0]       rs;
    logic [26:0]              ls;
    logic [79:0]              shr;
    logic [31:0]              sc_f;
    logic                     sc_sat;

    // Range check, length clamp and shift exponent arithmetic.
    always_comb begin
        reject = (s_harm_number < cfg_low) || (s_harm_number > cfg_high);
        wr_ok  = 32'(s_entry_index) < TABLE_DEPTH;
        if (cfg_len == 5'd0) begin
            len_c = DIV_VW'(1);
        end else if (32'(cfg_len) > TABLE_DEPTH) begin
            len_c = DIV_VW'(TABLE_DEPTH);
        end else begin
            len_c = DIV_VW'(cfg_len);
        end
        len5  = (DIV_VW+3)'(len_c) * (DIV_VW+3)'(5);
        mul_a = 32'($signed({1'b0, cfg_range})) * 32'(sh_reg);
        mul_b = 32'($signed({1'b0, len5})) * 32'(sh5_reg);
        n_val = 40'(num_reg) * 40'(EXP_TABLE_DEPTH)
              + $signed(40'(len_c)) * 40'(16384);
    end

    // Divider operand selection; both passes divide by the series length.
    always_comb begin
        case (cmd.div_op)
            DIV_TQ:  div_a = mv_reg;
            default: div_a = DIV_DW'(t_reg);
        endcase
        div_d = len_c;
    end

    hpf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_d),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // Final scaling by a power of two with saturation.
    always_comb begin
        rs     = 27'sd52 - 27'(p_reg);
        ls     = '0;
        shr    = '0;
        sc_f   = '0;
        sc_sat = 1'b0;
        if (rs < 0) begin
            ls = 27'(-rs);
            if (prod_reg == '0) begin
                sc_f = '0;
            end else if (ls >= 27'd32) begin
                sc_sat = 1'b1;
            end else if ((prod_reg >> (6'd32 - ls[5:0])) != '0) begin
                sc_sat = 1'b1;
            end else begin
                sc_f = prod_reg[31:0] << ls[4:0];
            end
        end else if (rs >= 80) begin
            sc_f = '0;
        end else begin
            shr    = prod_reg >> rs[6:0];
            sc_sat = |shr[79:32];
            sc_f   = shr[31:0];
        end
        if (sc_sat) begin
            sc_f = 32'hFFFF_FFFF;
        end
    end

    // Table memory write and registered reads.
    always_ff @(posedge aclk) begin
        if (cmd.load && !s_func && wr_ok) begin
            tbl_mem[TW'(s_entry_index)] <= s_ratio_value;
        end
        if (cmd.rd) begin
            rd_mem_reg <= tbl_mem[idx_reg];
            rd_vld_reg <= tbl_vld_reg[idx_reg];
            rd_def_reg <= just_ratio(TIDX_W'(idx_reg));
            e_reg      <= exp_rom[k_reg];
        end
    end

    // Arithmetic pipeline registers, stepped by the controller.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            t_reg   <= 9'(s_harm_number) + 9'(s_harm_offset);
            sh_reg  <= s_shift_amount;
            sh5_reg <= s_shift_five;
            if (!s_func) begin
                res_freq_reg   <= last_freq_reg;
                res_status_reg <= ST_WRITE;
            end else if (reject) begin
                res_freq_reg   <= last_freq_reg;
                res_status_reg <= ST_RANGE;
            end
        end
        if (cmd.num) begin
            num_reg <= 26'(mul_a + mul_b);
        end
        if (cmd.mval) begin
            mv_reg <= DIV_DW'(n_val >>> 15);
        end
        if (cmd.div_start) begin
            op_reg <= cmd.div_op;
        end
        if (div_done) begin
            case (op_reg)
                DIV_OCT: begin
                    oct_reg <= div_q;
                    idx_reg <= div_r[TW-1:0];
                end
                DIV_TQ: begin
                    // The exponent table depth is a power of two: the octave
                    // carry is a shift and the table index is a mask.
                    p_reg <= (DIV_DW+1)'(oct_reg) + (DIV_DW+1)'(div_q >>> KW);
                    k_reg <= div_q[KW-1:0];
                end
                default: begin
                end
            endcase
        end
        if (cmd.ma) begin
            a_reg <= 48'(cfg_fund) * 48'(rd_vld_reg ? rd_mem_reg : rd_def_reg);
        end
        if (cmd.mh) begin
            ph_reg <= 56'(a_reg[47:24]) * 56'(e_reg);
        end
        if (cmd.ml) begin
            prod_reg <= {ph_reg, 24'd0} + 80'(80'(a_reg[23:0]) * 80'(e_reg));
        end
        if (cmd.sc) begin
            res_freq_reg   <= sc_f;
            res_status_reg <= sc_sat ? ST_SAT : ST_OK;
        end
        if (cmd.out_load) begin
            m_freq_reg   <= res_freq_reg;
            m_status_reg <= res_status_reg;
        end
    end

    // Control state: written flags, last frequency and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_vld_reg   <= '0;
            last_freq_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load && !s_func && wr_ok) begin
                tbl_vld_reg[TW'(s_entry_index)] <= 1'b1;
            end
            if (cmd.sc) begin
                last_freq_reg <= sc_f;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_write  = !s_func;
    assign stat.is_reject = reject;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_frequency = m_freq_reg;
    assign m_status    = m_status_reg;

endmodule

FILE: sv/hpf_ctrl.sv
// Controller state machine that sequences the datapath for one word at a time.
// Depends on hpf_pkg for the command and status structs.
module hpf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output hpf_pkg::cmd_t  cmd,
    input  hpf_pkg::stat_t stat
);
    import hpf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NUM  = 4'd1;
    localparam logic [3:0] S_MVAL = 4'd2;
    localparam logic [3:0] S_D1GO = 4'd3;
    localparam logic [3:0] S_D1W  = 4'd4;
    localparam logic [3:0] S_D2GO = 4'd5;
    localparam logic [3:0] S_D2W  = 4'd6;
    localparam logic [3:0] S_RD   = 4'd9;
    localparam logic [3:0] S_MA   = 4'd10;
    localparam logic [3:0] S_MH   = 4'd11;
    localparam logic [3:0] S_ML   = 4'd12;
    localparam logic [3:0] S_SC   = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0] state_reg, state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (stat.is_write || stat.is_reject) ? S_DONE : S_NUM;
                end
            end
            S_NUM: begin
                cmd.num    = 1'b1;
                state_next = S_MVAL;
            end
            S_MVAL: begin
                cmd.mval   = 1'b1;
                state_next = S_D1GO;
            end
            S_D1GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_OCT;
                state_next    = S_D1W;
            end
            S_D1W: begin
                if (stat.div_done) begin
                    state_next = S_D2GO;
                end
            end
            S_D2GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_TQ;
                state_next    = S_D2W;
            end
            S_D2W: begin
                if (stat.div_done) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_MA;
            end
            S_MA: begin
                cmd.ma     = 1'b1;
                state_next = S_MH;
            end
            S_MH: begin
                cmd.mh     = 1'b1;
                state_next = S_ML;
            end
            S_ML: begin
                cmd.ml     = 1'b1;
                state_next = S_SC;
            end
            S_SC: begin
                cmd.sc     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

FILE: sv/harmonic_pitch_frequency_top.sv
// Top level of the harmonic pitch frequency block: configuration registers and glue.
// Depends on hpf_pkg, hpf_ctrl and hpf_datapath.
//
// Usage:
// The input channel (s_valid/s_ready) carries one word per item. A word with
// s_func low stores s_ratio_value in tuning entry s_entry_index; a word with
// s_func high turns a harmonic number into a Q20.12 frequency. The result
// channel (m_valid/m_ready) returns exactly one word per input word.
// A table write or a rejected harmonic skips the computation and goes from
// acceptance straight to the output step. A computed frequency takes two
// passes through the shared one-bit-per-cycle divider for the octave split
// and the shift exponent, then table reads, a split 48 by 32 bit multiply
// and the final scaling. One item is in work at a time, so no new word is
// taken until the last has gone to the output register. If the receiver
// stalls, the finished result holds in the output register and the next item
// stops at its last step until the register frees. aresetn (synchronous,
// active low) restores the just-intonation table, the configuration reset
// values, and a last frequency of zero; no clearing pass is needed. The user
// writes configuration over the APB port while idle; no check enforces it.
module harmonic_pitch_frequency_top #(
    parameter int TABLE_DEPTH     = 16,
    parameter int EXP_TABLE_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [3:0]         s_entry_index,
    input  logic [23:0]        s_ratio_value,
    input  logic signed [7:0]  s_harm_number,
    input  logic signed [7:0]  s_harm_offset,
    input  logic signed [15:0] s_shift_amount,
    input  logic signed [15:0] s_shift_five,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_frequency,
    output logic [1:0]         m_status
);
    import hpf_pkg::*;

    logic [23:0]       fund_reg;
    logic [4:0]        len_reg;
    logic [5:0]        range_reg;
    logic signed [7:0] low_reg, high_reg;
    logic              wr_en;
    cmd_t              cmd;
    stat_t             stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fund_reg  <= FUND_RST;
            len_reg   <= LEN_RST;
            range_reg <= RANGE_RST;
            low_reg   <= LOW_RST;
            high_reg  <= HIGH_RST;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_FUND:  fund_reg  <= pwdata[23:0];
                REG_LEN:   len_reg   <= pwdata[4:0];
                REG_RANGE: range_reg <= pwdata[5:0];
                REG_LOW:   low_reg   <= pwdata[7:0];
                REG_HIGH:  high_reg  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Configuration readback.
    always_comb begin
        unique case (paddr[4:2])
            REG_FUND:  prdata = 32'(fund_reg);
            REG_LEN:   prdata = 32'(len_reg);
            REG_RANGE: prdata = 32'(range_reg);
            REG_LOW:   prdata = 32'($unsigned(low_reg));
            REG_HIGH:  prdata = 32'($unsigned(high_reg));
            default:   prdata = '0;
        endcase
    end

    hpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    hpf_datapath #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_func         (s_func),
        .s_entry_index  (s_entry_index),
        .s_ratio_value  (s_ratio_value),
        .s_harm_number  (s_harm_number),
        .s_harm_offset  (s_harm_offset),
        .s_shift_amount (s_shift_amount),
        .s_shift_five   (s_shift_five),
        .cfg_fund       (fund_reg),
        .cfg_len        (len_reg),
        .cfg_range      (range_reg),
        .cfg_low        (low_reg),
        .cfg_high       (high_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frequency    (m_frequency),
        .m_status       (m_status)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for harmonic_pitch_frequency_top: directed table, then random words.
// Depends on hpf_pkg and the block's RTL; a built-in predictor checks every result word.
`timescale 1ns / 100ps

module testbench;
    import hpf_pkg::*;

    localparam int DEPTH     = 16;
    localparam int EXP_DEPTH = 64;
    localparam int LIMIT     = 1500000;

    logic               aclk;
    logic               aresetn;
    logic               psel, penable, pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic               s_func;
    logic [3:0]         s_entry_index;
    logic [23:0]        s_ratio_value;
    logic signed [7:0]  s_harm_number;
    logic signed [7:0]  s_harm_offset;
    logic signed [15:0] s_shift_amount;
    logic signed [15:0] s_shift_five;
    logic               m_valid;
    logic               m_ready;
    logic [31:0]        m_frequency;
    logic [1:0]         m_status;

    harmonic_pitch_frequency_top u_dut (.*);

    // One input word and one expected result word.
    typedef struct {
        logic        func;
        logic [3:0]  entry;
        logic [23:0] ratio;
        logic [7:0]  harm;
        logic [7:0]  hadd;
        logic [15:0] shamt;
        logic [15:0] sh5;
    } pitch_word_t;

    typedef struct {
        logic [31:0] freq;
        logic [1:0]  status;
    } freq_word_t;

    // Directed row: word, and an optional hand-typed expectation.
    typedef struct {
        pitch_word_t w;
        logic        typed;
        freq_word_t  res;
    } dir_row_t;

    // Predictor state.
    logic [23:0] tune_tbl [DEPTH];
    logic [31:0] prev_freq;
    logic [63:0] pow2_rom [EXP_DEPTH];
    logic [23:0] cfg_fund;
    logic [4:0]  cfg_len;
    logic [5:0]  cfg_range;
    logic [7:0]  cfg_low;
    logic [7:0]  cfg_high;

    freq_word_t  pending_freqs[$];
    int          fail_count;
    int          cycle_count;
    int          burst_left;
    int          gap_left;
    logic        rx_stall_en;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    task automatic build_pow2_rom();
        logic [63:0] x, term, sum;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            x = 64'(k) * LN2_Q30 / 64'(EXP_DEPTH);
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (int n = 1; n <= SERIES_TERMS; n++) begin
                term = ((term * x) >> 30) / 64'(n);
                sum  = sum + term;
            end
            pow2_rom[k] = sum;
        end
    endtask

    task automatic reset_predictor();
        logic [23:0] just [12];
        just = '{24'd4194304, 24'd4473924, 24'd4718592, 24'd5033165, 24'd5242880,
                 24'd5592405, 24'd5898240, 24'd6291456, 24'd6710886, 24'd6990507,
                 24'd7549747, 24'd7864320};
        for (int i = 0; i < DEPTH; i++) tune_tbl[i] = (i < 12) ? just[i] : ONE_Q22;
        prev_freq = '0;
        cfg_fund  = FUND_RST;
        cfg_len   = LEN_RST;
        cfg_range = RANGE_RST;
        cfg_low   = LOW_RST;
        cfg_high  = HIGH_RST;
    endtask

    // Computes the result word for one accepted input word and updates state.
    function automatic freq_word_t predict_frequency(pitch_word_t w);
        freq_word_t  r;
        longint      h, len, t, oct, idx, num, den, tq, tot, p, k, rs;
        logic [127:0] prod, sh;
        if (!w.func) begin
            tune_tbl[w.entry] = w.ratio;
            r.freq = prev_freq;
            r.status = ST_WRITE;
            return r;
        end
        h = longint'($signed(w.harm));
        if (h < longint'($signed(cfg_low)) || h > longint'($signed(cfg_high))) begin
            r.freq = prev_freq;
            r.status = ST_RANGE;
            return r;
        end
        len = cfg_len;
        if (len < 1) len = 1;
        if (len > DEPTH) len = DEPTH;
        t   = h + longint'($signed(w.hadd));
        oct = fdiv(t, len);
        idx = t - oct * len;
        num = longint'(cfg_range) * longint'($signed(w.shamt))
            + 5 * len * longint'($signed(w.sh5));
        den = len * 32768;
        tq  = fdiv(2 * num * EXP_DEPTH + den, 2 * den);
        tot = oct * EXP_DEPTH + tq;
        p   = fdiv(tot, EXP_DEPTH);
        k   = tot - p * EXP_DEPTH;
        prod = 128'(cfg_fund) * 128'(tune_tbl[idx]) * 128'(pow2_rom[k]);
        rs = 52 - p;
        r.status = ST_OK;
        if (rs >= 128) begin
            sh = '0;
        end else if (rs >= 0) begin
            sh = prod >> rs;
        end else if (prod == 0) begin
            sh = '0;
        end else begin
            // Left shift: saturate if any bit would pass bit 31.
            sh = ((-rs) > 32 || (prod >> (32 + rs)) != 0) ? {96'd1, 32'd0} : prod << (-rs);
        end
        if (sh[127:32] != 0) begin
            r.freq = '1;
            r.status = ST_SAT;
        end else begin
            r.freq = sh[31:0];
        end
        prev_freq = r.freq;
        return r;
    endfunction

    // APB register write: setup then access.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FUND:  cfg_fund  = val[23:0];
            REG_LEN:   cfg_len   = val[4:0];
            REG_RANGE: cfg_range = val[5:0];
            REG_LOW:   cfg_low   = val[7:0];
            REG_HIGH:  cfg_high  = val[7:0];
            default: ;
        endcase
    endtask

    // Drops valid after the last word and waits until every result is back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_freqs.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // Sends one word, with bursty gaps in front of it. Valid stays high
    // across back-to-back words and drops only when a gap follows.
    task automatic send_word(pitch_word_t w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
        burst_left--;
        if (gap_left > 0) begin
            s_valid <= 1'b0;
            repeat (gap_left) @(posedge aclk);
        end
        gap_left = 0;
        s_valid        <= 1'b1;
        s_func         <= w.func;
        s_entry_index  <= w.entry;
        s_ratio_value  <= w.ratio;
        s_harm_number  <= w.harm;
        s_harm_offset  <= w.hadd;
        s_shift_amount <= w.shamt;
        s_shift_five   <= w.sh5;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_freqs = {pending_freqs, predict_frequency(w)};
    endtask

    function automatic pitch_word_t rand_word(bit sane);
        pitch_word_t w;
        w.func  = ($urandom_range(0, 5) != 0);
        w.entry = $urandom_range(0, 15);
        w.ratio = sane ? 24'($urandom_range(2097152, 8388607)) : 24'($urandom);
        w.harm  = sane ? 8'($signed($urandom_range(0, 80)) - 24) : 8'($urandom);
        w.hadd  = sane ? 8'($signed($urandom_range(0, 16)) - 8) : 8'($urandom);
        w.shamt = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
        w.sh5   = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
        return w;
    endfunction

    // Result checker and receiver stall pattern.
    always @(posedge aclk) begin
        freq_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_freqs.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                exp_w = pending_freqs.pop_front();
                if (m_frequency !== exp_w.freq) begin
                    $error("frequency: expected %0d, got %0d", exp_w.freq, m_frequency);
                    fail_count++;
                end
                if (m_status !== exp_w.status) begin
                    $error("status: expected %0d, got %0d", exp_w.status, m_status);
                    fail_count++;
                end
            end
        end
        m_ready <= rx_stall_en ? (($urandom_range(0, 7) > 2) || cycle_count[9]) : 1'b1;
    end

    initial begin
        dir_row_t    rows[$];
        dir_row_t    row;
        freq_word_t  got;
        pitch_word_t w;
        fail_count = 0;
        cycle_count = 0;
        burst_left = 0;
        gap_left = 0;
        rx_stall_en = 1'b0;
        aresetn = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_func = 0; s_entry_index = '0; s_ratio_value = '0;
        s_harm_number = '0; s_harm_offset = '0; s_shift_amount = '0; s_shift_five = '0;
        m_ready = 1'b1;
        build_pow2_rom();
        reset_predictor();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: after reset, range rejects, writes, extremes, saturation.
        rows = '{
            '{'{1'b1, 4'd0, 24'd0, 8'd0, 8'd0, 16'd0, 16'd0}, 1'b1, '{32'd450560, ST_OK}},
            '{'{1'b1, 4'd0, 24'd0, -8'sd49, 8'd0, 16'd0, 16'd0}, 1'b1, '{32'd450560, ST_RANGE}},
            '{'{1'b1, 4'd0, 24'd0, 8'd97, 8'd0, 16'd0, 16'd0}, 1'b1, '{32'd450560, ST_RANGE}},
            '{'{1'b1, 4'd0, 24'd0, 8'd12, 8'd0, 16'd0, 16'd0}, 1'b1, '{32'd901120, ST_OK}},
            '{'{1'b0, 4'd15, 24'hFFFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1,
              '{32'd901120, ST_WRITE}},
            '{'{1'b0, 4'd0, 24'd0, 8'd0, 8'd0, 16'd0, 16'd0}, 1'b1, '{32'd901120, ST_WRITE}},
            '{'{1'b1, 4'd0, 24'd0, 8'd0, 8'd0, 16'd0, 16'd0}, 1'b1, '{32'd0, ST_OK}},
            '{'{1'b0, 4'd0, 24'd4194304, 8'd0, 8'd0, 16'd0, 16'd0}, 1'b0, '{0, 0}},
            '{'{1'b1, 4'd0, 24'd0, -8'sd48, -8'sd128, 16'h8000, 16'h8000}, 1'b0, '{0, 0}},
            '{'{1'b1, 4'd0, 24'd0, 8'd96, 8'd127, 16'h7FFF, 16'h7FFF}, 1'b1,
              '{32'hFFFFFFFF, ST_SAT}},
            '{'{1'b1, 4'hF, 24'hFFFFFF, 8'd5, 8'd3, 16'd1234, -16'sd77}, 1'b0, '{0, 0}},
            '{'{1'b1, 4'd0, 24'd0, 8'd11, 8'd0, 16'h7FFF, 16'd0}, 1'b0, '{0, 0}},
            '{'{1'b1, 4'd0, 24'd0, -8'sd1, 8'd0, 16'h8000, 16'd0}, 1'b0, '{0, 0}},
            '{'{1'b1, 4'd0, 24'd0, 8'd7, 8'd0, 16'd0, -16'sd32768}, 1'b0, '{0, 0}}
        };
        foreach (rows[i]) begin
            row = rows[i];
            send_word(row.w);
            if (row.typed) begin
                got = pending_freqs[$];
                if (got.freq !== row.res.freq || got.status !== row.res.status)
                    $error("predictor disagrees with directed row %0d", i);
            end
        end
        wait_drained();

        // Random phases over several register settings, extremes included.
        for (int ph = 0; ph < 8; ph++) begin
            rx_stall_en = ph[0];
            case (ph)
                1: begin
                    write_reg(REG_FUND, 32'hFFFFFF);
                    write_reg(REG_LEN, 32'd1);
                    write_reg(REG_RANGE, 32'd36);
                    write_reg(REG_LOW, 32'h80);
                    write_reg(REG_HIGH, 32'h7F);
                end
                2: begin
                    write_reg(REG_FUND, 32'd0);
                    write_reg(REG_LEN, 32'd16);
                    write_reg(REG_RANGE, 32'd0);
                end
                3: begin
                    write_reg(REG_LEN, 32'd0);
                    write_reg(REG_LOW, 32'd10);
                    write_reg(REG_HIGH, 32'hF6);
                end
                4: begin
                    write_reg(REG_LEN, 32'd31);
                    write_reg(REG_LOW, 32'hE0);
                    write_reg(REG_HIGH, 32'd60);
                    write_reg(REG_FUND, 32'd123456);
                end
                5, 6, 7: begin
                    write_reg(REG_FUND, $urandom_range(0, 24'hFFFFFF));
                    write_reg(REG_LEN, $urandom_range(1, 16));
                    write_reg(REG_RANGE, $urandom_range(0, 36));
                    write_reg(REG_LOW, $urandom_range(256 - 40, 255));
                    write_reg(REG_HIGH, $urandom_range(40, 127));
                end
                default: ;
            endcase
            for (int n = 0; n < 140; n++) begin
                w = rand_word($urandom_range(0, 4) != 0);
                send_word(w);
                // Hold the sender until everything has come back.
                if (n == 70) begin
                    s_valid <= 1'b0;
                    while (pending_freqs.size() != 0) @(posedge aclk);
                end
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/hpf_pkg.sv
sv/hpf_div.sv
sv/hpf_datapath.sv
sv/hpf_ctrl.sv
sv/harmonic_pitch_frequency_top.sv
tb/testbench.sv
